@@ rtl/elpm_pkg.sv @@
// ----------------------------------------------------------------------------
// elpm_pkg
// Shared types, command codes and store geometry for the exception list
// packet marker.
// ----------------------------------------------------------------------------
package elpm_pkg;

    // Request command codes
    localparam logic [2:0] CMD_CLASSIFY       = 3'd0;
    localparam logic [2:0] CMD_ADD_NUMBER     = 3'd1;
    localparam logic [2:0] CMD_CLEAR_NUMBERS  = 3'd2;
    localparam logic [2:0] CMD_ADD_VERSION    = 3'd3;
    localparam logic [2:0] CMD_CLEAR_VERSIONS = 3'd4;

    // enable_modes bit positions
    localparam int MODE_NUMBER_BIT  = 0;
    localparam int MODE_VERSION_BIT = 1;

    // Number set: banked memory, one row of lanes read per cycle
    localparam int NUMBER_CAPACITY = 256;
    localparam int NUM_LANE_BITS   = 3;
    localparam int NUM_LANES       = 1 << NUM_LANE_BITS;
    localparam int NUM_ROWS        = (NUMBER_CAPACITY + NUM_LANES - 1) / NUM_LANES;
    localparam int NUM_ROW_W       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int NUM_IDX_W       = NUM_ROW_W + NUM_LANE_BITS;
    localparam int NUM_CMP_W       = NUM_IDX_W + 1;
    localparam int NUM_CNT_W       = $clog2(NUMBER_CAPACITY + 1);

    // Version set: register file, compared in parallel
    localparam int VERSION_CAPACITY = 16;
    localparam int VER_IDX_W        = (VERSION_CAPACITY > 1) ? $clog2(VERSION_CAPACITY) : 1;
    localparam int VER_CNT_W        = $clog2(VERSION_CAPACITY + 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic finish;
    } elpm_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } elpm_stat_t;

endpackage

@@ rtl/elpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// elpm_ctrl
// Sequencer: takes a request, runs the number set scan when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module elpm_ctrl
    import elpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  elpm_stat_t stat,
    output elpm_ctrl_t ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.need_scan)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last row compare lands this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is only loaded into a free output slot
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending result");

    // A new request always moves to decode
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DECIDE))
        else $error("accepted request not decoded");

    // Output valid only rises out of the finish step
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("output valid raised outside finish");

endmodule

@@ rtl/elpm_datapath.sv @@
// ----------------------------------------------------------------------------
// elpm_datapath
// Request registers, number and version sets, row scan compare and the
// result register.
// ----------------------------------------------------------------------------
module elpm_datapath
    import elpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  command,
    input  logic [31:0] account_number,
    input  logic [15:0] client_version,
    input  logic        is_tcp_or_udp,
    input  logic        flow_eligible,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    input  elpm_ctrl_t  ctl,
    output elpm_stat_t  stat,
    output logic        add_ok,
    output logic        matched,
    output logic        mark_packet,
    output logic        mark_connection
);

    // Request registers
    logic [2:0]  cmd_reg;
    logic [31:0] num_reg;
    logic [15:0] ver_reg;
    logic        l4_reg;
    logic        elig_reg;
    logic [1:0]  mode_reg;

    // Set state
    logic [NUM_CNT_W-1:0] num_count_reg;
    logic [VER_CNT_W-1:0] ver_count_reg;
    logic [15:0]          ver_store_reg [VERSION_CAPACITY];
    logic [31:0]          num_mem [NUM_ROWS][NUM_LANES];

    // Scan pipeline
    logic [NUM_ROW_W-1:0] row_ptr_reg;
    logic [31:0]          rd_row_reg [NUM_LANES];
    logic [NUM_ROW_W-1:0] rd_idx_reg;
    logic                 rd_en_reg;
    logic                 hit_reg;

    // Result registers
    logic add_ok_reg;
    logic matched_reg;
    logic mark_pkt_reg;
    logic mark_conn_reg;

    logic                 ver_hit;
    logic                 lane_hit;
    logic                 num_mode;
    logic                 ver_mode;
    logic                 cls_ok;
    logic                 num_room;
    logic                 ver_room;
    logic [NUM_IDX_W-1:0] last_idx;
    logic [NUM_IDX_W-1:0] wr_idx;
    logic [VER_IDX_W-1:0] ver_wr_idx;
    logic                 res_add_ok;
    logic                 res_matched;
    logic                 res_pkt;
    logic                 res_conn;
    logic                 num_wr;
    logic                 ver_wr;

    assign num_mode   = mode_reg[MODE_NUMBER_BIT];
    assign ver_mode   = mode_reg[MODE_VERSION_BIT];
    assign cls_ok     = l4_reg && elig_reg;
    assign num_room   = (num_count_reg < NUM_CNT_W'(NUMBER_CAPACITY));
    assign ver_room   = (ver_count_reg < VER_CNT_W'(VERSION_CAPACITY));
    assign last_idx   = NUM_IDX_W'(num_count_reg - 1'b1);
    assign wr_idx     = NUM_IDX_W'(num_count_reg);
    assign ver_wr_idx = VER_IDX_W'(ver_count_reg);

    // Version set lookup, all slots at once
    always_comb
    begin
        ver_hit = 1'b0;
        for (int i = 0; i < VERSION_CAPACITY; i++)
        begin
            if ((VER_CNT_W'(i) < ver_count_reg) && (ver_store_reg[i] == ver_reg))
            begin
                ver_hit = 1'b1;
            end
        end
    end

    // Compare of the row read last cycle
    always_comb
    begin
        lane_hit = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if ((NUM_CMP_W'({rd_idx_reg, NUM_LANE_BITS'(l)}) < NUM_CMP_W'(num_count_reg))
                && (rd_row_reg[l] == num_reg))
            begin
                lane_hit = 1'b1;
            end
        end
    end

    // Scan status
    always_comb
    begin
        stat.scan_last = (row_ptr_reg == last_idx[NUM_IDX_W-1:NUM_LANE_BITS]);
        stat.need_scan = 1'b0;
        if (num_count_reg != '0)
        begin
            if (cmd_reg == CMD_ADD_NUMBER)
            begin
                stat.need_scan = 1'b1;
            end
            else if ((cmd_reg == CMD_CLASSIFY) && cls_ok && !(ver_mode && ver_hit)
                     && num_mode && (num_reg != '0))
            begin
                stat.need_scan = 1'b1;
            end
        end
    end

    // Result decode
    always_comb
    begin
        res_add_ok  = 1'b0;
        res_matched = 1'b0;
        res_pkt     = 1'b0;
        res_conn    = 1'b0;
        num_wr      = 1'b0;
        ver_wr      = 1'b0;
        unique case (cmd_reg)
            CMD_CLASSIFY:
            begin
                if (cls_ok)
                begin
                    if (ver_mode && ver_hit)
                    begin
                        res_matched = 1'b1;
                        res_pkt     = 1'b1;
                        res_conn    = 1'b1;
                    end
                    else if (num_mode)
                    begin
                        if (num_reg == '0)
                        begin
                            res_pkt = 1'b1;
                        end
                        else if (hit_reg)
                        begin
                            res_matched = 1'b1;
                            res_pkt     = 1'b1;
                            res_conn    = 1'b1;
                        end
                    end
                end
            end
            CMD_ADD_NUMBER:
            begin
                num_wr     = !hit_reg && num_room;
                res_add_ok = num_wr;
            end
            CMD_ADD_VERSION:
            begin
                ver_wr     = !ver_hit && ver_room;
                res_add_ok = ver_wr;
            end
            default:
            begin
                // clears and unused codes answer all zero
            end
        endcase
    end

    // Request, result and scan row index capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            num_reg  <= account_number;
            ver_reg  <= client_version;
            l4_reg   <= is_tcp_or_udp;
            elig_reg <= flow_eligible;
        end
        if (ctl.finish)
        begin
            add_ok_reg    <= res_add_ok;
            matched_reg   <= res_matched;
            mark_pkt_reg  <= res_pkt;
            mark_conn_reg <= res_conn;
        end
        if (ctl.scan_step)
        begin
            rd_idx_reg <= row_ptr_reg;
        end
    end

    // Number set memory
    always_ff @(posedge clk)
    begin
        if (ctl.finish && num_wr)
        begin
            num_mem[wr_idx[NUM_IDX_W-1:NUM_LANE_BITS]][wr_idx[NUM_LANE_BITS-1:0]] <= num_reg;
        end
        if (ctl.scan_step)
        begin
            rd_row_reg <= num_mem[row_ptr_reg];
        end
    end

    // Version set storage
    always_ff @(posedge clk)
    begin
        if (ctl.finish && ver_wr)
        begin
            ver_store_reg[ver_wr_idx] <= ver_reg;
        end
    end

    // Control state: modes, fill counts, scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            num_count_reg <= '0;
            ver_count_reg <= '0;
            row_ptr_reg   <= '0;
            rd_en_reg     <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (ctl.scan_start)
            begin
                row_ptr_reg <= '0;
            end
            else if (ctl.scan_step)
            begin
                row_ptr_reg <= row_ptr_reg + 1'b1;
            end
            rd_en_reg <= ctl.scan_step;
            if (ctl.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (rd_en_reg && lane_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (ctl.finish)
            begin
                if (cmd_reg == CMD_CLEAR_NUMBERS)
                begin
                    num_count_reg <= '0;
                end
                else if (num_wr)
                begin
                    num_count_reg <= num_count_reg + 1'b1;
                end
                if (cmd_reg == CMD_CLEAR_VERSIONS)
                begin
                    ver_count_reg <= '0;
                end
                else if (ver_wr)
                begin
                    ver_count_reg <= ver_count_reg + 1'b1;
                end
            end
        end
    end

    assign add_ok          = add_ok_reg;
    assign matched         = matched_reg;
    assign mark_packet     = mark_pkt_reg;
    assign mark_connection = mark_conn_reg;

    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        num_count_reg <= NUM_CNT_W'(NUMBER_CAPACITY))
        else $error("number count past capacity");

    a_ver_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ver_count_reg <= VER_CNT_W'(VERSION_CAPACITY))
        else $error("version count past capacity");

    // Fill count only grows by one or drops to empty
    a_num_step: assert property (@(posedge clk) disable iff (!rst_n)
        (num_count_reg != $past(num_count_reg)) |->
            ((num_count_reg == $past(num_count_reg) + 1'b1) || (num_count_reg == '0)))
        else $error("number count jumped");

    // Count changes only when a request finishes
    a_count_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.finish) |=> $stable(num_count_reg) && $stable(ver_count_reg))
        else $error("set changed outside finish");

endmodule

@@ rtl/exception_list_packet_marker.sv @@
// ----------------------------------------------------------------------------
// exception_list_packet_marker
// Exception number / client version set keeper and packet classifier.
// ----------------------------------------------------------------------------
// Flow: accept, decide, finish for requests with no number scan; add-number and
// number-mode classify with n > 0 stored numbers add row scan and drain steps first.
// One request at a time: the next is taken once the current one finishes; the row scan
// (8 entries per memory read) sets the long case. The result register frees the input side.
// Reset: both sets empty (fill counts cleared), enable_modes 0, no clearing pass.
// ----------------------------------------------------------------------------
module exception_list_packet_marker
    import elpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] account_number,
    input  logic [15:0] client_version,
    input  logic        is_tcp_or_udp,
    input  logic        flow_eligible,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        add_ok,
    output logic        matched,
    output logic        mark_packet,
    output logic        mark_connection
);

    elpm_ctrl_t ctl;
    elpm_stat_t stat;

    // Sequencer
    elpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Sets and result datapath
    elpm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .account_number  (account_number),
        .client_version  (client_version),
        .is_tcp_or_udp   (is_tcp_or_udp),
        .flow_eligible   (flow_eligible),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .ctl             (ctl),
        .stat            (stat),
        .add_ok          (add_ok),
        .matched         (matched),
        .mark_packet     (mark_packet),
        .mark_connection (mark_connection)
    );

endmodule
